@@ hdl/crd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package crd_pkg;
    localparam int unsigned MaxResolution = 4096;
    localparam int unsigned PixW   = 12;
    localparam int unsigned UvW    = 28;
    localparam int unsigned WordW  = 32;
    localparam int unsigned CompW  = 47;
    localparam int unsigned ScaleW = 31;
    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned DivSteps  = 31;
    localparam int unsigned CfgIdxW = 4;

    typedef enum logic [CfgIdxW-1:0] {
        REG_EYE_X  = 4'd0,
        REG_EYE_Y  = 4'd1,
        REG_EYE_Z  = 4'd2,
        REG_LEFT_X = 4'd3,
        REG_TOP_Y  = 4'd4,
        REG_FILM_Z = 4'd5,
        REG_STEP_X = 4'd6,
        REG_STEP_Y = 4'd7
    } crd_reg_e;

    typedef struct packed {
        logic [UvW-1:0] u;
        logic [UvW-1:0] v;
    } crd_uv_t;

    typedef struct packed {
        logic signed [WordW-1:0] eye_x;
        logic signed [WordW-1:0] eye_y;
        logic signed [WordW-1:0] eye_z;
        logic signed [WordW-1:0] left_x;
        logic signed [WordW-1:0] top_y;
        logic signed [WordW-1:0] film_z;
        logic signed [WordW-1:0] step_x;
        logic signed [WordW-1:0] step_y;
    } crd_cfg_t;

    typedef struct packed {
        logic [2:0][ScaleW-1:0] mag;
        logic [2:0]             neg;
        logic                   degen;
    } crd_side_t;

    typedef struct packed {
        logic [63:0] n;
        logic [35:0] rem;
        logic [31:0] root;
        crd_side_t   side;
    } crd_sq_t;

    typedef struct packed {
        logic [31:0]            r;
        logic [2:0][ScaleW-1:0] nlo;
        logic [2:0][31:0]       rem;
        logic [2:0][ScaleW-1:0] q;
        logic [2:0]             neg;
        logic                   degen;
    } crd_dv_t;

    // bit length of a nonzero word, 0 for zero
    function automatic logic [5:0] bit_len(input logic [CompW-1:0] w);
        logic [5:0] l;
        l = '0;
        for (int i = 0; i < CompW; i++) begin
            if (w[i]) begin
                l = 6'(i + 1);
            end
        end
        return l;
    endfunction
endpackage
`default_nettype wire

@@ hdl/crd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crd_front import crd_pkg::*; #(
    parameter int unsigned MAX_RESOLUTION = MaxResolution
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [55:0]   s_tdata,
    input  wire logic          pop,
    output logic               head_valid,
    output crd_uv_t            head
);
    localparam logic [16:0] PixMax = 17'(MAX_RESOLUTION - 1);

    crd_uv_t     q_reg [0:1];
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        do_pop;
    logic        load_head;
    logic [PixW-1:0] px, py;
    crd_uv_t     item;

    always_comb
    begin
        px = s_tdata[11:0];
        py = s_tdata[23:12];
        if ({5'b0, px} > PixMax)
        begin
            px = PixMax[PixW-1:0];
        end
        if ({5'b0, py} > PixMax)
        begin
            py = PixMax[PixW-1:0];
        end
        item.u = {px, s_tdata[39:24]};
        item.v = {py, s_tdata[55:40]};
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[0];
    assign do_pop     = pop && head_valid;
    assign cnt_next   = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    // new request goes straight to the head when the queue empties under it
    assign load_head  = push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && do_pop));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // two-entry queue, entry 0 is the head
    always_ff @(posedge clk)
    begin
        if (load_head)
        begin
            q_reg[0] <= item;
        end
        else if (do_pop)
        begin
            q_reg[0] <= q_reg[1];
        end
        if (push && !load_head)
        begin
            q_reg[1] <= item;
        end
    end
endmodule
`default_nettype wire

@@ hdl/crd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crd_back import crd_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire crd_cfg_t    cfg,
    input  wire logic        in_valid,
    input  wire crd_uv_t     in_uv,
    output logic             take,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [95:0]      out_data,
    output logic             out_degen
);
    logic en;
    assign en   = !out_valid || out_ready;
    assign take = en;

    // products
    logic                    v1_reg;
    logic signed [60:0]      px_reg, py_reg;
    // components
    logic                    v2_reg;
    logic signed [CompW-1:0] c_reg [0:2];
    // magnitudes
    logic                    v3_reg;
    logic [CompW-1:0]        m_reg [0:2];
    logic [2:0]              n3_reg;
    logic [CompW-1:0]        or_reg;
    // bit length
    logic                    v4_reg;
    logic [CompW-1:0]        m4_reg [0:2];
    logic [2:0]              n4_reg;
    logic [5:0]              len_reg;
    // scaled
    logic                    v5_reg;
    crd_side_t               s5_reg;
    // squares
    logic                    v6_reg;
    crd_side_t               s6_reg;
    logic [61:0]             sq_reg [0:2];

    logic                    sv_reg [0:SqrtSteps];
    crd_sq_t                 st_reg [0:SqrtSteps];
    logic                    dv_vld_reg [0:DivSteps];
    crd_dv_t                 dv_reg [0:DivSteps];

    logic [95:0]             out_data_reg;
    logic                    out_degen_reg;
    logic                    out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            out_valid_reg <= dv_vld_reg[DivSteps];
        end
    end

    logic signed [44:0] offx, offy;
    assign offx = px_reg[60:16];
    assign offy = py_reg[60:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 61'($signed({1'b0, in_uv.u}) * cfg.step_x);
            py_reg <= 61'($signed({1'b0, in_uv.v}) * cfg.step_y);
            c_reg[0] <= CompW'(cfg.left_x) + CompW'(offx) - CompW'(cfg.eye_x);
            c_reg[1] <= CompW'(cfg.top_y) + CompW'(offy) - CompW'(cfg.eye_y);
            c_reg[2] <= CompW'(cfg.film_z) - CompW'(cfg.eye_z);
            for (int i = 0; i < 3; i++)
            begin
                n3_reg[i] <= c_reg[i][CompW-1];
                m_reg[i]  <= c_reg[i][CompW-1] ? CompW'(-c_reg[i]) : c_reg[i];
            end
            or_reg <= (c_reg[0][CompW-1] ? CompW'(-c_reg[0]) : c_reg[0])
                    | (c_reg[1][CompW-1] ? CompW'(-c_reg[1]) : c_reg[1])
                    | (c_reg[2][CompW-1] ? CompW'(-c_reg[2]) : c_reg[2]);
            m4_reg  <= m_reg;
            n4_reg  <= n3_reg;
            len_reg <= bit_len(or_reg);
            // bring the largest magnitude into [2^30, 2^31)
            for (int i = 0; i < 3; i++)
            begin
                if (len_reg > 6'd31)
                begin
                    s5_reg.mag[i] <= ScaleW'(m4_reg[i] >> (len_reg - 6'd31));
                end
                else
                begin
                    s5_reg.mag[i] <= ScaleW'(m4_reg[i] << (6'd31 - len_reg));
                end
            end
            s5_reg.neg   <= n4_reg;
            s5_reg.degen <= (len_reg == 6'd0);
            s6_reg <= s5_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 62'(s5_reg.mag[i] * s5_reg.mag[i]);
            end
            st_reg[0].n    <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            st_reg[0].rem  <= '0;
            st_reg[0].root <= '0;
            st_reg[0].side <= s6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= v6_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SqrtSteps; k++)
    begin : g_sqrt
        logic [35:0] cur;
        logic [35:0] trial;
        assign cur   = {st_reg[k].rem[33:0], st_reg[k].n[63-2*k -: 2]};
        assign trial = {2'b0, st_reg[k].root, 2'b01};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k+1].n    <= st_reg[k].n;
                st_reg[k+1].side <= st_reg[k].side;
                if (cur >= trial)
                begin
                    st_reg[k+1].rem  <= cur - trial;
                    st_reg[k+1].root <= {st_reg[k].root[30:0], 1'b1};
                end
                else
                begin
                    st_reg[k+1].rem  <= cur;
                    st_reg[k+1].root <= {st_reg[k].root[30:0], 1'b0};
                end
            end
        end
    end

    // dividend mag*2^30 + r/2; its top 31 bits start the remainder
    logic [61:0] numer [0:2];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            numer[i] = {st_reg[SqrtSteps].side.mag[i], 31'b0} >> 1;
            numer[i] = numer[i] + 62'(st_reg[SqrtSteps].root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sv_reg[SqrtSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].r     <= st_reg[SqrtSteps].root;
            dv_reg[0].neg   <= st_reg[SqrtSteps].side.neg;
            dv_reg[0].degen <= st_reg[SqrtSteps].side.degen;
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[0].rem[i] <= {1'b0, numer[i][61:31]};
                dv_reg[0].nlo[i] <= numer[i][30:0];
                dv_reg[0].q[i]   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar j = 0; j < DivSteps; j++)
    begin : g_div
        logic [32:0] cur [0:2];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur[i] = {dv_reg[j].rem[i], dv_reg[j].nlo[i][DivSteps-1-j]};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j+1].r     <= dv_reg[j].r;
                dv_reg[j+1].nlo   <= dv_reg[j].nlo;
                dv_reg[j+1].neg   <= dv_reg[j].neg;
                dv_reg[j+1].degen <= dv_reg[j].degen;
                for (int i = 0; i < 3; i++)
                begin
                    if (cur[i] >= {1'b0, dv_reg[j].r})
                    begin
                        dv_reg[j+1].rem[i] <= 32'(cur[i] - {1'b0, dv_reg[j].r});
                        dv_reg[j+1].q[i]   <= {dv_reg[j].q[i][29:0], 1'b1};
                    end
                    else
                    begin
                        dv_reg[j+1].rem[i] <= cur[i][31:0];
                        dv_reg[j+1].q[i]   <= {dv_reg[j].q[i][29:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_degen_reg <= dv_reg[DivSteps].degen;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[DivSteps].degen)
                begin
                    out_data_reg[32*i +: 32] <= '0;
                end
                else if (dv_reg[DivSteps].neg[i])
                begin
                    out_data_reg[32*i +: 32] <= 32'(-{1'b0, dv_reg[DivSteps].q[i]});
                end
                else
                begin
                    out_data_reg[32*i +: 32] <= {1'b0, dv_reg[DivSteps].q[i]};
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_degen = out_degen_reg;
endmodule
`default_nettype wire

@@ hdl/camera_ray_direction_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// pinhole camera ray direction
// s_* channel takes one request per pixel: tdata holds pixel_x, pixel_y,
// jitter_x, jitter_y from the lowest bit up; each request gives one result
// on m_*: tdata holds dir_x, dir_y, dir_z (Q2.30), tuser the degenerate flag
// cfg_* writes the camera registers (eye, film corner, film z, steps);
// write only while no request is in flight, cfg_ready is always high
// throughput: one request per cycle while m_tready stays high
// a request passes the 7-stage scale path, the 32-stage square root
// and the 31-stage divider lanes
// a two-entry queue parts the front from the back pipeline
// when a result waits with m_tready low the whole back pipeline holds; the
// queue then fills and s_tready drops
// reset empties the pipeline and queue and loads the register defaults
// (film z at 1.0, everything else zero)
module camera_ray_direction_core import crd_pkg::*; #(
    parameter int unsigned MAX_RESOLUTION = MaxResolution
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // pixel_x, pixel_y, jitter_x, jitter_y
    input  wire logic [55:0]         s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // dir_x, dir_y, dir_z
    output logic [95:0]              m_tdata,
    // degenerate
    output logic                     m_tuser,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [WordW-1:0]    cfg_data
);
    localparam crd_cfg_t CfgReset = '{
        eye_x: '0, eye_y: '0, eye_z: '0, left_x: '0, top_y: '0,
        film_z: 32'sd65536, step_x: '0, step_y: '0
    };

    crd_cfg_t cfg_reg;
    logic     head_valid;
    crd_uv_t  head;
    logic     take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_EYE_X:  cfg_reg.eye_x  <= cfg_data;
                REG_EYE_Y:  cfg_reg.eye_y  <= cfg_data;
                REG_EYE_Z:  cfg_reg.eye_z  <= cfg_data;
                REG_LEFT_X: cfg_reg.left_x <= cfg_data;
                REG_TOP_Y:  cfg_reg.top_y  <= cfg_data;
                REG_FILM_Z: cfg_reg.film_z <= cfg_data;
                REG_STEP_X: cfg_reg.step_x <= cfg_data;
                REG_STEP_Y: cfg_reg.step_y <= cfg_data;
                default:    ;
            endcase
        end
    end

    crd_front #(
        .MAX_RESOLUTION(MAX_RESOLUTION)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .pop       (take),
        .head_valid(head_valid),
        .head      (head)
    );

    crd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (head_valid),
        .in_uv    (head),
        .take     (take),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_degen(m_tuser)
    );
endmodule
`default_nettype wire

@@ hdl/crd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tuser
);
    // a degenerate ray carries a zero direction
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 96'b0))
        else $error("degenerate result with nonzero direction");

    // a normal ray always has a nonzero z or some nonzero component
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata != 96'b0))
        else $error("zero direction without degenerate flag");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed under stall");

    // nothing comes out the cycle after reset is released
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid straight out of reset");
endmodule

bind camera_ray_direction_core crd_checker u_crd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire
